// File: design/vpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_pkg: shared types and constants of the video payload packetizer
// Beat layouts, state record, register indexes and codes used by the core,
// the top level and the port checker.
// ----------------------------------------------------------------------------
package vpp_pkg;

  // Width of sizes, positions and offsets
  localparam int SIZE_BITS = 24;
  typedef logic [SIZE_BITS-1:0] size_t;

  // Request kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_STALL = 2'd1;
  localparam logic [1:0] ST_DEFER = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_PAYLOAD    = 2'd0;
  localparam logic [1:0] REG_FRAME_BYTES    = 2'd1;
  localparam logic [1:0] REG_WATCHDOG_LIMIT = 2'd2;

  // Register reset values
  localparam size_t      MAX_PAYLOAD_RST    = 24'd460800;
  localparam size_t      FRAME_BYTES_RST    = 24'd921600;
  localparam logic [7:0] WATCHDOG_LIMIT_RST = 8'd60;

  // Payload header
  localparam size_t      HDR_BYTES  = 24'd6;
  localparam logic [2:0] HDR_LEN    = 3'd6;
  localparam logic [7:0] FLAG_EOF   = 8'h02;
  localparam logic [7:0] FLAG_TIME  = 8'h04;
  localparam logic [7:0] FLAG_EOH   = 8'h80;
  localparam logic [3:0] STREAM_EP  = 4'd1;
  localparam logic [7:0] TICKS_SAT  = 8'hFF;
  localparam size_t      SIZE_ONES  = {SIZE_BITS{1'b1}};

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  endpoint;
    logic        direction_in;
    logic [23:0] buffer_size;
    logic [15:0] feature_value;
    logic [15:0] request_length;
  } vpp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  header_length;
    logic [7:0]  header_flags;
    logic [31:0] timestamp;
    logic [23:0] frame_offset;
    logic [23:0] data_length;
    logic        arm_timer;
    logic        capture_on;
    logic        capture_changed;
    logic        fetch_next_frame;
    logic        completes_deferred;
  } vpp_out_t;

  typedef struct packed {
    size_t      max_payload;
    size_t      frame_bytes;
    logic [7:0] watchdog_limit;
  } vpp_cfg_t;

  typedef struct packed {
    size_t       frame_position;
    size_t       payload_position;
    logic [31:0] frame_count;
    logic        toggle_bit;
    logic        frame_done_hold;
    logic        capturing;
    logic [7:0]  idle_ticks;
    logic        pending_valid;
    size_t       pending_size;
  } vpp_state_t;

endpackage

// File: design/vpp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_step: packet decision logic
// Works out the result beat and the next stream state for one request from
// the current state and the configuration registers.
// ----------------------------------------------------------------------------
module vpp_step (
  input  vpp_pkg::vpp_in_t    item,
  input  vpp_pkg::vpp_state_t st,
  input  vpp_pkg::vpp_cfg_t   cfg,
  output vpp_pkg::vpp_state_t st_nxt,
  output vpp_pkg::vpp_out_t   res
);
  import vpp_pkg::*;

  size_t             srv_size;
  size_t             win;
  size_t             hlen;
  size_t             dlen;
  size_t             pp_base;
  logic [SIZE_BITS:0] reach_sum;
  logic [SIZE_BITS:0] pp_sum;
  logic              srv_stall;
  logic              hdr;
  logic              reach;
  vpp_state_t        srv_st;
  vpp_out_t          srv_res;
  logic              ep_ok;

  // Pick the buffer size: a tick serves the deferred request
  assign srv_size = (item.kind == KIND_TICK) ? st.pending_size : item.buffer_size;
  assign ep_ok    = item.direction_in && (item.endpoint == STREAM_EP);

  // Size the packet window
  always_comb begin
    win       = (srv_size < cfg.max_payload) ? srv_size : cfg.max_payload;
    srv_stall = (win <= HDR_BYTES) || (st.frame_position >= cfg.frame_bytes);
    hdr       = (st.payload_position == '0) || (st.payload_position >= cfg.max_payload);
    hlen      = hdr ? HDR_BYTES : '0;
    reach_sum = {1'b0, st.frame_position} + {1'b0, win} - {1'b0, hlen};
    reach     = reach_sum >= {1'b0, cfg.frame_bytes};
    dlen      = reach ? (cfg.frame_bytes - st.frame_position) : (win - hlen);
    pp_base   = hdr ? '0 : st.payload_position;
    pp_sum    = {1'b0, pp_base} + {1'b0, win};
  end

  // Serve one packet: state after the packet and its descriptor
  always_comb begin
    srv_st  = st;
    srv_res = '0;
    if (srv_stall) begin
      srv_res.status = ST_STALL;
    end else begin
      srv_res.status          = ST_OK;
      srv_res.arm_timer       = (st.frame_position == '0) || (st.idle_ticks != '0) ||
                                !st.capturing;
      srv_res.capture_changed = !st.capturing;
      srv_res.header_length   = hdr ? HDR_LEN : 3'd0;
      srv_res.header_flags    = hdr ? (FLAG_EOH | FLAG_TIME | {7'd0, st.toggle_bit}) : 8'd0;
      srv_res.timestamp       = hdr ? st.frame_count : 32'd0;
      srv_res.frame_offset    = st.frame_position;
      srv_res.data_length     = dlen;
      srv_st.idle_ticks       = '0;
      srv_st.capturing        = 1'b1;
      if (reach) begin
        srv_res.header_flags    = srv_res.header_flags | FLAG_EOF;
        srv_st.payload_position = '0;
        srv_st.toggle_bit       = !st.toggle_bit;
        srv_st.frame_count      = st.frame_count + 32'd1;
        srv_st.frame_done_hold  = 1'b1;
        srv_st.frame_position   = '0;
      end else begin
        srv_st.payload_position = pp_sum[SIZE_BITS] ? SIZE_ONES : pp_sum[SIZE_BITS-1:0];
        srv_st.frame_position   = st.frame_position + dlen;
      end
    end
  end

  // Dispatch on the request kind
  always_comb begin
    st_nxt     = st;
    res        = '0;
    res.status = ST_NONE;
    unique case (item.kind)
      KIND_DATA: begin
        if (!ep_ok) begin
          res.status = ST_STALL;
        end else if (st.frame_done_hold) begin
          res.status          = ST_DEFER;
          st_nxt.pending_valid = 1'b1;
          st_nxt.pending_size  = item.buffer_size;
        end else begin
          res    = srv_res;
          st_nxt = srv_st;
        end
      end
      KIND_TICK: begin
        if (!st.pending_valid) begin
          if (st.frame_done_hold ||
              ((st.idle_ticks != '0) && (st.idle_ticks >= cfg.watchdog_limit))) begin
            res.capture_changed    = st.capturing;
            st_nxt.capturing       = 1'b0;
            st_nxt.frame_done_hold = 1'b0;
          end else begin
            if (st.idle_ticks != TICKS_SAT) begin
              st_nxt.idle_ticks = st.idle_ticks + 8'd1;
            end
            res.arm_timer = 1'b1;
          end
        end else begin
          res                      = srv_res;
          st_nxt                   = srv_st;
          st_nxt.pending_valid     = 1'b0;
          st_nxt.frame_done_hold   = !srv_stall && reach;
          res.fetch_next_frame     = 1'b1;
          res.completes_deferred   = !srv_stall;
        end
      end
      KIND_CLEAR: begin
        if ((item.request_length != '0) || !ep_ok || (item.feature_value != '0)) begin
          res.status = ST_STALL;
        end else begin
          res.status           = ST_OK;
          st_nxt.pending_valid = 1'b0;
        end
      end
      default: begin
        res.status = ST_NONE;
      end
    endcase
    res.capture_on = st_nxt.capturing;
  end

endmodule

// File: design/video_payload_packetizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_payload_packetizer: bulk IN packet descriptor generator
// Cuts video frames into payload packets with optional stream headers.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (data packet, timer tick, endpoint clear) arrive as beats on
//   in_valid/in_stall/in_data; each request yields exactly one descriptor
//   beat on out_valid/out_stall/out_data, in order.
//   cfg_we/cfg_addr/cfg_wdata write max_payload, frame_bytes and
//   watchdog_limit; write them only while no request is in flight.
//   An accepted beat passes the input register, then the decision logic into
//   the result register, which drives the result beat.
//   Throughput is one beat per cycle while the result side is not stalled; the
//   stream state loop is plain compares and adds, so requests follow back to back.
//   A stalled result holds in the result register; the request behind it
//   waits in the input register, and in_stall rises only when both are full.
//   Synchronous reset (rst_n low) empties both registers, clears the stream
//   state and loads the register defaults (460800, 921600, 60).
// ----------------------------------------------------------------------------
module video_payload_packetizer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [23:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  vpp_pkg::vpp_in_t      in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output vpp_pkg::vpp_out_t     out_data
);
  import vpp_pkg::*;

  logic       in_valid_r;
  vpp_in_t    in_data_r;
  logic       out_valid_r;
  vpp_out_t   out_data_r;
  vpp_state_t state_r;
  vpp_state_t state_nxt;
  vpp_cfg_t   cfg_r;
  vpp_out_t   res;
  logic       advance;

  // Advance when the result register is free or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  vpp_step u_step (
    .item   (in_data_r),
    .st     (state_r),
    .cfg    (cfg_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_payload    <= MAX_PAYLOAD_RST;
      cfg_r.frame_bytes    <= FRAME_BYTES_RST;
      cfg_r.watchdog_limit <= WATCHDOG_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAX_PAYLOAD:    cfg_r.max_payload    <= cfg_wdata;
        REG_FRAME_BYTES:    cfg_r.frame_bytes    <= cfg_wdata;
        REG_WATCHDOG_LIMIT: cfg_r.watchdog_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input register: take a beat whenever it is empty or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // Stream state: update as a request moves into the result register;
  // the deferred buffer size carries no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.frame_position   <= '0;
      state_r.payload_position <= '0;
      state_r.frame_count      <= '0;
      state_r.toggle_bit       <= 1'b0;
      state_r.frame_done_hold  <= 1'b0;
      state_r.capturing        <= 1'b0;
      state_r.idle_ticks       <= '0;
      state_r.pending_valid    <= 1'b0;
    end else if (in_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/vpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_checker: port-level checks of the video payload packetizer
// Watches the channels of the top level and flags descriptor beats that
// break the packet rules; attached by a bind below.
// ----------------------------------------------------------------------------
module vpp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input vpp_pkg::vpp_out_t out_data
);
  import vpp_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // Stalled or deferred requests carry no packet and start nothing
  a_refused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.status == ST_STALL) || (out_data.status == ST_DEFER)) |->
      (out_data.header_length == 3'd0) && (out_data.data_length == '0) &&
      !out_data.arm_timer && !out_data.capture_changed)
    else $error("refused request carries packet data");

  // A header is all or nothing: six bytes with end-of-header and time flags
  a_header_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_data.header_length == 3'd0) && !out_data.header_flags[7]) ||
      ((out_data.header_length == HDR_LEN) && out_data.header_flags[7] &&
       out_data.header_flags[2]))
    else $error("malformed payload header");

  // Completing a deferred request needs a successful fetch on a tick
  a_deferred_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.completes_deferred |->
      out_data.fetch_next_frame && (out_data.status == ST_OK))
    else $error("deferred completion without served packet");

endmodule

bind video_payload_packetizer vpp_checker u_vpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the video payload packetizer
// Drives request beats with random gaps and random result back-pressure,
// predicts every descriptor from an internal model of the stream state and
// compares each result beat field by field, across several register settings.
// ----------------------------------------------------------------------------
module tb;
  import vpp_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_addr  = REG_MAX_PAYLOAD;
  logic [23:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  vpp_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  vpp_out_t   out_data;

  // Shaping of idle cycles on both sides
  bit steady = 1'b0;
  int mismatches = 0;

  // Predicted stream state, registers and descriptors still to come
  vpp_cfg_t   regs;
  vpp_state_t strm;
  vpp_out_t   desc_due[$];

  video_payload_packetizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // Cut one payload window from the frame; stalls leave the state alone
  function automatic vpp_out_t serve_window(input size_t host_buf);
    vpp_out_t            r;
    size_t               win;
    size_t               hdr;
    logic [SIZE_BITS:0]  span;
    logic [SIZE_BITS:0]  pay_sum;
    logic                arm;
    r   = '0;
    hdr = '0;
    win = (host_buf < regs.max_payload) ? host_buf : regs.max_payload;
    arm = (strm.frame_position == '0);
    if (win <= HDR_BYTES || strm.frame_position >= regs.frame_bytes) begin
      r.status = ST_STALL;
      return r;
    end
    if (strm.idle_ticks != '0) begin
      strm.idle_ticks = '0;
      arm = 1'b1;
    end
    if (!strm.capturing) begin
      strm.capturing    = 1'b1;
      arm               = 1'b1;
      r.capture_changed = 1'b1;
    end
    // Open a new payload transfer with a header
    if (strm.payload_position == '0 || strm.payload_position >= regs.max_payload) begin
      hdr                   = HDR_BYTES;
      r.header_length       = HDR_LEN;
      r.header_flags        = FLAG_EOH | FLAG_TIME | {7'd0, strm.toggle_bit};
      r.timestamp           = strm.frame_count;
      strm.payload_position = '0;
    end
    r.frame_offset = strm.frame_position;
    span = {1'b0, strm.frame_position} + {1'b0, win} - {1'b0, hdr};
    if (span >= {1'b0, regs.frame_bytes}) begin
      // Last packet of the frame: flip toggle, count, hold
      r.data_length         = regs.frame_bytes - strm.frame_position;
      r.header_flags        = r.header_flags | FLAG_EOF;
      strm.payload_position = '0;
      strm.toggle_bit       = ~strm.toggle_bit;
      strm.frame_count      = strm.frame_count + 32'd1;
      strm.frame_done_hold  = 1'b1;
      strm.frame_position   = '0;
    end else begin
      r.data_length         = win - hdr;
      pay_sum               = {1'b0, strm.payload_position} + {1'b0, win};
      strm.payload_position = pay_sum[SIZE_BITS] ? SIZE_ONES : pay_sum[SIZE_BITS-1:0];
      strm.frame_position   = strm.frame_position + r.data_length;
    end
    r.status    = ST_OK;
    r.arm_timer = arm;
    return r;
  endfunction

  // Descriptor that one accepted request produces
  function automatic vpp_out_t packetize(input vpp_in_t req);
    vpp_out_t r;
    logic     stream_in;
    r         = '0;
    r.status  = ST_NONE;
    stream_in = req.direction_in && (req.endpoint == STREAM_EP);
    case (req.kind)
      KIND_DATA: begin
        if (!stream_in) begin
          r.status = ST_STALL;
        end else if (strm.frame_done_hold) begin
          r.status           = ST_DEFER;
          strm.pending_valid = 1'b1;
          strm.pending_size  = req.buffer_size;
        end else begin
          r = serve_window(req.buffer_size);
        end
      end
      KIND_TICK: begin
        if (!strm.pending_valid) begin
          if (strm.frame_done_hold ||
              (strm.idle_ticks != '0 && strm.idle_ticks >= regs.watchdog_limit)) begin
            r.capture_changed    = strm.capturing;
            strm.capturing       = 1'b0;
            strm.frame_done_hold = 1'b0;
          end else begin
            if (strm.idle_ticks != TICKS_SAT) strm.idle_ticks = strm.idle_ticks + 8'd1;
            r.arm_timer = 1'b1;
          end
        end else begin
          // Release the hold and serve the kept request
          strm.pending_valid   = 1'b0;
          strm.frame_done_hold = 1'b0;
          r = serve_window(strm.pending_size);
          r.fetch_next_frame   = 1'b1;
          r.completes_deferred = (r.status == ST_OK);
        end
      end
      KIND_CLEAR: begin
        if (req.request_length != '0 || !stream_in || req.feature_value != '0) begin
          r.status = ST_STALL;
        end else begin
          strm.pending_valid = 1'b0;
          r.status           = ST_OK;
        end
      end
      default: ;
    endcase
    r.capture_on = strm.capturing;
    return r;
  endfunction

  function automatic vpp_in_t make_req(input logic [1:0] kind, input logic [3:0] ep,
                                       input logic dir, input size_t bsize,
                                       input logic [15:0] feat, input logic [15:0] rlen);
    vpp_in_t req;
    req.kind           = kind;
    req.endpoint       = ep;
    req.direction_in   = dir;
    req.buffer_size    = bsize;
    req.feature_value  = feat;
    req.request_length = rlen;
    return req;
  endfunction

  // Send one request beat; valid stays up between back-to-back beats
  task automatic push_request(input vpp_in_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    desc_due.push_back(packetize(req));
  endtask

  // Drop valid, wait for every outstanding descriptor, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (desc_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers while the block is idle
  task automatic load_regs(input size_t mp, input size_t fb, input logic [7:0] wd);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_MAX_PAYLOAD;
    cfg_wdata <= mp;
    @(posedge clk);
    cfg_addr  <= REG_FRAME_BYTES;
    cfg_wdata <= fb;
    @(posedge clk);
    cfg_addr  <= REG_WATCHDOG_LIMIT;
    cfg_wdata <= {junk, wd};
    @(posedge clk);
    cfg_we <= 1'b0;
    regs.max_payload    = mp;
    regs.frame_bytes    = fb;
    regs.watchdog_limit = wd;
  endtask

  // Window limits, endpoint checks and unknown kind under reset registers
  task automatic test_basic_stream();
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd0, 16'h0, 16'h0));
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd6, 16'h0, 16'h0));
    push_request(make_req(KIND_DATA, 4'd2, 1'b1, 24'd100, 16'h0, 16'h0));
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b0, 24'd100, 16'h0, 16'h0));
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd7, 16'h0, 16'h0));
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, SIZE_ONES, 16'h0, 16'h0));
    push_request(make_req(KIND_UNUSED, 4'hF, 1'b1, SIZE_ONES, 16'hFFFF, 16'hFFFF));
  endtask

  // Frame end, deferred requests, release by tick and endpoint clears
  task automatic test_frame_end();
    load_regs(24'd20, 24'd30, 8'd3);
    repeat (3) push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd20, 16'h0, 16'h0));
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd9, 16'h0, 16'h0));
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd12, 16'h0, 16'h0));
    push_request(make_req(KIND_TICK, 4'd0, 1'b0, 24'd0, 16'h0, 16'h0));
    repeat (2) push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd20, 16'h0, 16'h0));
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd15, 16'h0, 16'h0));
    push_request(make_req(KIND_CLEAR, STREAM_EP, 1'b1, 24'd0, 16'h0, 16'h0001));
    push_request(make_req(KIND_CLEAR, STREAM_EP, 1'b1, 24'd0, 16'hFFFF, 16'h0));
    push_request(make_req(KIND_CLEAR, 4'd0, 1'b1, 24'd0, 16'h0, 16'h0));
    push_request(make_req(KIND_CLEAR, STREAM_EP, 1'b0, 24'd0, 16'h0, 16'h0));
    push_request(make_req(KIND_CLEAR, STREAM_EP, 1'b1, 24'd0, 16'h0, 16'h0));
    repeat (2) push_request(make_req(KIND_TICK, 4'd0, 1'b0, 24'd0, 16'h0, 16'h0));
  endtask

  // Payload position saturation and frame position beyond a shrunk frame
  task automatic test_position_limits();
    load_regs(SIZE_ONES, SIZE_ONES, 8'd60);
    push_request(make_req(KIND_TICK, 4'd0, 1'b0, 24'd0, 16'h0, 16'h0));
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'h800000, 16'h0, 16'h0));
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'h800002, 16'h0, 16'h0));
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd16, 16'h0, 16'h0));
    push_request(make_req(KIND_TICK, 4'd0, 1'b0, 24'd0, 16'h0, 16'h0));
    load_regs(24'd100, 24'd1000, 8'd60);
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd100, 16'h0, 16'h0));
    load_regs(24'd100, 24'd50, 8'd60);
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd100, 16'h0, 16'h0));
    load_regs(24'd7, 24'd1, 8'd60);
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd7, 16'h0, 16'h0));
    load_regs(24'd7, 24'd200, 8'd60);
    repeat (2) push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd7, 16'h0, 16'h0));
  endtask

  // Watchdog at both ends of its range
  task automatic test_watchdog();
    load_regs(24'd64, SIZE_ONES, 8'd1);
    repeat (3) push_request(make_req(KIND_TICK, 4'd0, 1'b0, 24'd0, 16'h0, 16'h0));
    load_regs(24'd64, SIZE_ONES, 8'd255);
    push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, 24'd64, 16'h0, 16'h0));
    repeat (257) push_request(make_req(KIND_TICK, 4'd0, 1'b0, 24'd0, 16'h0, 16'h0));
  endtask

  // Phases of mostly well-formed streaming with ticks, clears and noise
  task automatic test_random_traffic();
    size_t       mp;
    size_t       fb;
    size_t       bsize;
    logic [7:0]  wd;
    int          phase;
    int          n;
    int          pick;
    for (phase = 0; phase < 20; phase++) begin
      case ($urandom_range(0, 9))
        0:       mp = 24'd7;
        1:       mp = SIZE_ONES;
        2:       mp = 24'($urandom_range(7, 16777215));
        default: mp = 24'($urandom_range(7, 64));
      endcase
      case ($urandom_range(0, 9))
        0:       fb = 24'd1;
        1:       fb = SIZE_ONES;
        2:       fb = 24'($urandom_range(1, 16777215));
        default: fb = 24'($urandom_range(1, 400));
      endcase
      case ($urandom_range(0, 5))
        0:       wd = 8'd1;
        1:       wd = 8'd255;
        default: wd = 8'($urandom_range(1, 12));
      endcase
      // Keep the frame ahead of the current position in most phases
      if ($urandom_range(0, 7) != 0 && fb <= strm.frame_position)
        fb = (strm.frame_position > 24'hFFFF00) ? SIZE_ONES
                                                 : strm.frame_position +
                                                   24'($urandom_range(1, 200));
      load_regs(mp, fb, wd);
      steady = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 100; n++) begin
        case ($urandom_range(0, 9))
          0:       bsize = 24'($urandom_range(0, 6));
          1:       bsize = 24'($urandom_range(0, 16777215));
          2:       bsize = regs.max_payload;
          default: bsize = 24'($urandom_range(7, (regs.max_payload > 300) ? 300
                                                                    : regs.max_payload + 8));
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 62)
          push_request(make_req(KIND_DATA, STREAM_EP, 1'b1, bsize,
                                16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535))));
        else if (pick < 80)
          push_request(make_req(KIND_TICK, 4'($urandom_range(0, 15)),
                                1'($urandom_range(0, 1)), bsize,
                                16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535))));
        else if (pick < 85)
          push_request(make_req(KIND_CLEAR, STREAM_EP, 1'b1, bsize, 16'h0, 16'h0));
        else
          push_request(make_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                1'($urandom_range(0, 1)), 24'($urandom_range(0, 16777215)),
                                ($urandom_range(0, 1) != 0) ? 16'h0
                                                            : 16'($urandom_range(0, 65535)),
                                ($urandom_range(0, 1) != 0) ? 16'h0
                                                            : 16'($urandom_range(0, 65535))));
      end
    end
    steady = 1'b0;
  endtask

  // Back-pressure on the result side: a run of stalls, then a free cycle
  initial begin : stall_driver
    int run;
    run = 0;
    forever begin
      @(posedge clk);
      if (run > 0) begin
        out_stall <= 1'b1;
        run--;
      end else begin
        out_stall <= 1'b0;
        run = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    vpp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (desc_due.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatches++;
      end else begin
        want = desc_due.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("header_length", 32'(want.header_length),
                    32'(out_data.header_length));
        check_field("header_flags", 32'(want.header_flags), 32'(out_data.header_flags));
        check_field("timestamp", want.timestamp, out_data.timestamp);
        check_field("frame_offset", 32'(want.frame_offset), 32'(out_data.frame_offset));
        check_field("data_length", 32'(want.data_length), 32'(out_data.data_length));
        check_field("arm_timer", 32'(want.arm_timer), 32'(out_data.arm_timer));
        check_field("capture_on", 32'(want.capture_on), 32'(out_data.capture_on));
        check_field("capture_changed", 32'(want.capture_changed),
                    32'(out_data.capture_changed));
        check_field("fetch_next_frame", 32'(want.fetch_next_frame),
                    32'(out_data.fetch_next_frame));
        check_field("completes_deferred", 32'(want.completes_deferred),
                    32'(out_data.completes_deferred));
      end
    end
  end

  initial begin
    regs.max_payload    = MAX_PAYLOAD_RST;
    regs.frame_bytes    = FRAME_BYTES_RST;
    regs.watchdog_limit = WATCHDOG_LIMIT_RST;
    strm = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_stream();
    test_frame_end();
    test_position_limits();
    test_watchdog();
    test_random_traffic();
    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  // Hard stop if the stream hangs
  initial begin : watchdog_timer
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule

// File: sim.f
design/vpp_pkg.sv
design/vpp_step.sv
design/video_payload_packetizer.sv
design/vpp_checker.sv
sim/tb.sv
